/* sv/js_string_literal_decoder_assert.svh */
// Assertion helpers for the string literal decoder.
`ifndef JS_STRING_LITERAL_DECODER_ASSERT_SVH
`define JS_STRING_LITERAL_DECODER_ASSERT_SVH

// Same-cycle implication.
`define JSSL_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("jssl implication check failed");

// Next-cycle implication.
`define JSSL_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("jssl next-cycle check failed");

`endif

/* sv/jssl_pkg.sv */
package jssl_pkg;

   typedef logic [20:0] cp_type;
   typedef logic [1:0]  status_type;

   localparam status_type ST_CHAR   = 2'd0;
   localparam status_type ST_CLOSED = 2'd1;
   localparam status_type ST_ERROR  = 2'd2;

   localparam cp_type CP_MAX      = 21'h10ffff;
   localparam cp_type BRACE_LIMIT = CP_MAX >> 4;

   // front-to-back queue and result buffer geometry
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [3:0] {
      CL_OTHER,
      CL_SQUOTE,
      CL_DQUOTE,
      CL_BSLASH,
      CL_LF,
      CL_CR,
      CL_LSPS,
      CL_OVER,
      CL_X,
      CL_U,
      CL_LBRACE,
      CL_RBRACE
   } cls_type;

   typedef struct packed {
      logic       eoi;
      cls_type    cls;
      logic       is_oct;
      logic       is_hex;
      logic [3:0] hex_val;
      cp_type     cp;
      cp_type     esc_val;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      cp_type     decoded_char;
      status_type status;
      logic       last_of_run;
   } result_type;

   typedef struct packed {
      logic              take;
      logic [QCNT_W-1:0] out_count;
   } back_stat_type;

endpackage

/* sv/jssl_if.sv */
interface jssl_req_if;
   logic             valid;
   logic             ready;
   jssl_pkg::cp_type code_point;
   logic             end_of_input;

   modport source (output valid, output code_point, output end_of_input, input ready);
   modport sink (input valid, input code_point, input end_of_input, output ready);
endinterface

interface jssl_rsp_if;
   logic                 valid;
   logic                 ready;
   jssl_pkg::cp_type     decoded_char;
   jssl_pkg::status_type status;
   logic                 last_of_run;

   modport source (output valid, output decoded_char, output status, output last_of_run,
                   input ready);
   modport sink (input valid, input decoded_char, input status, input last_of_run,
                 output ready);
endinterface

/* sv/jssl_front.sv */
module jssl_front (
   jssl_req_if.sink           req_chan,
   input  logic               q_full,
   output jssl_pkg::push_type push
);
   import jssl_pkg::*;

   localparam cp_type CH_DQUOTE = 21'h22;
   localparam cp_type CH_SQUOTE = 21'h27;
   localparam cp_type CH_0      = 21'h30;
   localparam cp_type CH_7      = 21'h37;
   localparam cp_type CH_9      = 21'h39;
   localparam cp_type CH_UA     = 21'h41;
   localparam cp_type CH_UF     = 21'h46;
   localparam cp_type CH_BSLASH = 21'h5c;
   localparam cp_type CH_LA     = 21'h61;
   localparam cp_type CH_LB     = 21'h62;
   localparam cp_type CH_LF_    = 21'h66;
   localparam cp_type CH_N      = 21'h6e;
   localparam cp_type CH_R      = 21'h72;
   localparam cp_type CH_T      = 21'h74;
   localparam cp_type CH_U      = 21'h75;
   localparam cp_type CH_V      = 21'h76;
   localparam cp_type CH_X      = 21'h78;
   localparam cp_type CH_LBRACE = 21'h7b;
   localparam cp_type CH_RBRACE = 21'h7d;
   localparam cp_type CP_LF     = 21'h0a;
   localparam cp_type CP_CR     = 21'h0d;
   localparam cp_type CP_LS     = 21'h2028;
   localparam cp_type CP_PS     = 21'h2029;

   cp_type  cp;
   cls_type cls;
   cp_type  esc_val;
   logic    is_dec;
   logic    is_alpha_hex;

   assign cp = req_chan.code_point;

   always_comb begin
      if (cp > CP_MAX) begin
         cls = CL_OVER;
      end else begin
         case (cp)
            CH_SQUOTE: cls = CL_SQUOTE;
            CH_DQUOTE: cls = CL_DQUOTE;
            CH_BSLASH: cls = CL_BSLASH;
            CP_LF:     cls = CL_LF;
            CP_CR:     cls = CL_CR;
            CP_LS,
            CP_PS:     cls = CL_LSPS;
            CH_X:      cls = CL_X;
            CH_U:      cls = CL_U;
            CH_LBRACE: cls = CL_LBRACE;
            CH_RBRACE: cls = CL_RBRACE;
            default:   cls = CL_OTHER;
         endcase
      end
   end

   // single-character escapes; everything else passes through
   always_comb begin
      case (cp)
         CH_LB:   esc_val = 21'd8;
         CH_LF_:  esc_val = 21'd12;
         CH_N:    esc_val = 21'd10;
         CH_R:    esc_val = 21'd13;
         CH_T:    esc_val = 21'd9;
         CH_V:    esc_val = 21'd11;
         default: esc_val = cp;
      endcase
   end

   assign is_dec       = cp inside {[CH_0:CH_9]};
   assign is_alpha_hex = (cp inside {[CH_UA:CH_UF]}) || (cp inside {[CH_LA:CH_LF_]});

   assign req_chan.ready    = !q_full;
   assign push.valid        = req_chan.valid && !q_full;
   assign push.item.eoi     = req_chan.end_of_input;
   assign push.item.cls     = cls;
   assign push.item.is_oct  = cp inside {[CH_0:CH_7]};
   assign push.item.is_hex  = is_dec || is_alpha_hex;
   assign push.item.hex_val = is_dec ? cp[3:0] : cp[3:0] + 4'd9;
   assign push.item.cp      = cp;
   assign push.item.esc_val = esc_val;

endmodule

/* sv/jssl_queue.sv */
module jssl_queue (
   input  logic               clock,
   input  logic               reset,
   input  jssl_pkg::push_type push,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output jssl_pkg::item_type head
);
   import jssl_pkg::*;

   item_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == QCNT_W'(QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.valid);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      cnt_in    = cnt_ff + QCNT_W'(push.valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

/* sv/jssl_back.sv */
module jssl_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  jssl_pkg::item_type      head,
   output logic                    pop,
   jssl_rsp_if.source              rsp_chan,
   output jssl_pkg::back_stat_type stat
);
   import jssl_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_BODY,
      PH_ESC,
      PH_ESC_CR,
      PH_OCT,
      PH_HEX,
      PH_U_START,
      PH_U4,
      PH_UB_EMPTY,
      PH_UB_ZEROS,
      PH_UB_DIGITS
   } phase_type;

   typedef struct packed {
      logic       emit;
      result_type res;
      logic       to_idle;
      logic       to_esc;
   } body_out_type;

   function automatic body_out_type body_step(item_type it, logic single);
      body_out_type o;
      o = '0;
      if ((single && it.cls == CL_SQUOTE) || (!single && it.cls == CL_DQUOTE)) begin
         o.emit       = 1'b1;
         o.res.status = ST_CLOSED;
         o.to_idle    = 1'b1;
      end else if (it.cls == CL_BSLASH) begin
         o.to_esc = 1'b1;
      end else if (it.cls == CL_LF || it.cls == CL_CR || it.cls == CL_OVER) begin
         o.emit       = 1'b1;
         o.res.status = ST_ERROR;
         o.to_idle    = 1'b1;
      end else begin
         o.emit             = 1'b1;
         o.res.decoded_char = it.cp;
         o.res.status       = ST_CHAR;
      end
      return o;
   endfunction

   phase_type         phase_ff, phase_in;
   logic              single_ff, single_in;
   cp_type            value_ff, value_in;
   logic [1:0]        dcnt_ff, dcnt_in;

   result_type        obuf_ff [QDEPTH];
   logic [QPTR_W-1:0] owr_ff, owr_in;
   logic [QPTR_W-1:0] ord_ff, ord_in;
   logic [QCNT_W-1:0] ocnt_ff, ocnt_in;

   result_type        res [2];
   logic [1:0]        n;
   logic              take;
   logic              out_pop;
   body_out_type      bo;
   cp_type            oct_next;

   // room for the worst case of two results before taking an item
   assign take    = head_valid && (ocnt_ff <= QCNT_W'(QDEPTH - 2));
   assign pop     = take;
   assign out_pop = rsp_chan.valid && rsp_chan.ready;

   assign stat.take      = take;
   assign stat.out_count = ocnt_ff;

   assign oct_next = {value_ff[17:0], head.hex_val[2:0]};

   always_comb begin
      phase_in  = phase_ff;
      single_in = single_ff;
      value_in  = value_ff;
      dcnt_in   = dcnt_ff;
      res[0]    = '0;
      res[1]    = '0;
      n         = 2'd0;
      bo        = '0;

      if (take) begin
         if (head.eoi) begin
            if (phase_ff != PH_IDLE) begin
               if (phase_ff == PH_OCT) begin
                  res[0].decoded_char = value_ff;
                  res[0].status       = ST_CHAR;
                  n                   = 2'd1;
               end
               res[n[0]].status = ST_ERROR;
               n                = n + 2'd1;
               phase_in         = PH_IDLE;
               single_in        = 1'b0;
               value_in         = '0;
               dcnt_in          = '0;
            end
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (head.cls == CL_SQUOTE || head.cls == CL_DQUOTE) begin
                     single_in = (head.cls == CL_SQUOTE);
                     phase_in  = PH_BODY;
                     value_in  = '0;
                     dcnt_in   = '0;
                  end else begin
                     res[0].status = ST_ERROR;
                     n             = 2'd1;
                  end
               end
               PH_BODY, PH_ESC_CR, PH_OCT: begin
                  phase_in = PH_BODY;
                  value_in = '0;
                  dcnt_in  = '0;
                  if (phase_ff == PH_OCT && head.is_oct) begin
                     // third digit, or second after a leading 4..7, ends the escape
                     if (dcnt_ff >= 2'd2 || oct_next[20:5] != '0) begin
                        res[0].decoded_char = oct_next;
                        n                   = 2'd1;
                     end else begin
                        phase_in = PH_OCT;
                        value_in = oct_next;
                        dcnt_in  = 2'd2;
                     end
                  end else if (!(phase_ff == PH_ESC_CR && head.cls == CL_LF)) begin
                     if (phase_ff == PH_OCT) begin
                        res[0].decoded_char = value_ff;
                        n                   = 2'd1;
                     end
                     bo = body_step(head, single_ff);
                     if (bo.emit) begin
                        res[n[0]] = bo.res;
                        n         = n + 2'd1;
                     end
                     if (bo.to_idle) begin
                        phase_in  = PH_IDLE;
                        single_in = 1'b0;
                     end else if (bo.to_esc) begin
                        phase_in = PH_ESC;
                     end
                  end
               end
               PH_ESC: begin
                  value_in = '0;
                  dcnt_in  = '0;
                  if (head.cls == CL_LF || head.cls == CL_LSPS) begin
                     phase_in = PH_BODY;
                  end else if (head.cls == CL_CR) begin
                     phase_in = PH_ESC_CR;
                     value_in = value_ff;
                     dcnt_in  = dcnt_ff;
                  end else if (head.is_oct) begin
                     phase_in = PH_OCT;
                     value_in = cp_type'(head.hex_val[2:0]);
                     dcnt_in  = 2'd1;
                  end else if (head.cls == CL_X) begin
                     phase_in = PH_HEX;
                  end else if (head.cls == CL_U) begin
                     phase_in = PH_U_START;
                  end else if (head.cls == CL_OVER) begin
                     res[0].status = ST_ERROR;
                     n             = 2'd1;
                     phase_in      = PH_IDLE;
                     single_in     = 1'b0;
                  end else begin
                     res[0].decoded_char = head.esc_val;
                     n                   = 2'd1;
                     phase_in            = PH_BODY;
                  end
               end
               PH_HEX, PH_U_START, PH_U4: begin
                  if (phase_ff == PH_U_START && head.cls == CL_LBRACE) begin
                     phase_in = PH_UB_EMPTY;
                  end else if (!head.is_hex) begin
                     res[0].status = ST_ERROR;
                     n             = 2'd1;
                     phase_in      = PH_IDLE;
                     single_in     = 1'b0;
                     value_in      = '0;
                     dcnt_in       = '0;
                  end else if (phase_ff == PH_U_START) begin
                     phase_in = PH_U4;
                     value_in = cp_type'(head.hex_val);
                     dcnt_in  = 2'd1;
                  end else if (phase_ff == PH_HEX) begin
                     value_in = {13'd0, value_ff[3:0], head.hex_val};
                     dcnt_in  = 2'd1;
                     if (dcnt_ff != 2'd0) begin
                        res[0].decoded_char = {13'd0, value_ff[3:0], head.hex_val};
                        n                   = 2'd1;
                        phase_in            = PH_BODY;
                        value_in            = '0;
                        dcnt_in             = '0;
                     end
                  end else begin
                     value_in = {5'd0, value_ff[11:0], head.hex_val};
                     dcnt_in  = dcnt_ff + 2'd1;
                     if (dcnt_ff == 2'd3) begin
                        res[0].decoded_char = {5'd0, value_ff[11:0], head.hex_val};
                        n                   = 2'd1;
                        phase_in            = PH_BODY;
                        value_in            = '0;
                        dcnt_in             = '0;
                     end
                  end
               end
               PH_UB_EMPTY, PH_UB_ZEROS, PH_UB_DIGITS: begin
                  if (head.cls == CL_RBRACE && phase_ff != PH_UB_EMPTY) begin
                     res[0].decoded_char = (phase_ff == PH_UB_ZEROS) ? '0 : value_ff;
                     n                   = 2'd1;
                     phase_in            = PH_BODY;
                     value_in            = '0;
                     dcnt_in             = '0;
                  end else if (head.cls == CL_RBRACE || !head.is_hex ||
                               (phase_ff == PH_UB_DIGITS && value_ff > BRACE_LIMIT)) begin
                     res[0].status = ST_ERROR;
                     n             = 2'd1;
                     phase_in      = PH_IDLE;
                     single_in     = 1'b0;
                     value_in      = '0;
                     dcnt_in       = '0;
                  end else if (phase_ff != PH_UB_DIGITS && head.hex_val == 4'd0) begin
                     phase_in = PH_UB_ZEROS;
                  end else begin
                     // value stays at or below the 0x10FFF limit, so this fits
                     value_in = {value_ff[16:0], head.hex_val};
                     phase_in = PH_UB_DIGITS;
                  end
               end
               default: begin
                  phase_in  = PH_IDLE;
                  single_in = 1'b0;
                  value_in  = '0;
                  dcnt_in   = '0;
               end
            endcase
         end
      end

      if (n == 2'd2) begin
         res[1].last_of_run = 1'b1;
      end else if (n == 2'd1) begin
         res[0].last_of_run = 1'b1;
      end

      owr_in  = owr_ff + QPTR_W'(n);
      ord_in  = ord_ff + QPTR_W'(out_pop);
      ocnt_in = ocnt_ff + QCNT_W'(n) - QCNT_W'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         single_ff <= 1'b0;
         value_ff  <= '0;
         dcnt_ff   <= '0;
         owr_ff    <= '0;
         ord_ff    <= '0;
         ocnt_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         single_ff <= single_in;
         value_ff  <= value_in;
         dcnt_ff   <= dcnt_in;
         owr_ff    <= owr_in;
         ord_ff    <= ord_in;
         ocnt_ff   <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n != 2'd0) begin
         obuf_ff[owr_ff] <= res[0];
      end
      if (n == 2'd2) begin
         obuf_ff[owr_ff + QPTR_W'(1)] <= res[1];
      end
   end

   assign rsp_chan.valid        = (ocnt_ff != '0);
   assign rsp_chan.decoded_char = obuf_ff[ord_ff].decoded_char;
   assign rsp_chan.status       = obuf_ff[ord_ff].status;
   assign rsp_chan.last_of_run  = obuf_ff[ord_ff].last_of_run;

endmodule

/* sv/js_string_literal_decoder.sv */
// Channel   Dir  Transaction
// req_chan  in   one source code point (code_point, end_of_input)
// rsp_chan  out  one decoded result (decoded_char, status, last_of_run)
//
// One code point per cycle sustained while the result buffer has room; a code point that
// yields two results writes both into the result buffer together. Front classification
// feeds a 4-entry queue, then the escape state machine writes a 4-entry result buffer.
// Reset is synchronous and clears the state machine, queue and buffer pointers.
// rsp_chan.ready low fills the result buffer, then the queue, then drops req ready.
`include "js_string_literal_decoder_assert.svh"

module js_string_literal_decoder (
   input logic        clock,
   input logic        reset,
   jssl_req_if.sink   req_chan,
   jssl_rsp_if.source rsp_chan
);
   import jssl_pkg::*;

   push_type      push;
   logic          q_full;
   logic          q_pop;
   logic          head_valid;
   item_type      head;
   back_stat_type stat;

   jssl_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push)
   );

   jssl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   jssl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (q_pop),
      .rsp_chan   (rsp_chan),
      .stat       (stat)
   );

   // first of a result pair is only visible once its partner is buffered
   `JSSL_ASSERT_IMPLY(a_pair_buffered, clock, reset, rsp_chan.valid && !rsp_chan.last_of_run, stat.out_count >= QCNT_W'(2))
   `JSSL_ASSERT_IMPLY(a_status_clears_char, clock, reset, rsp_chan.valid && rsp_chan.status != ST_CHAR, rsp_chan.decoded_char == '0)
   `JSSL_ASSERT_IMPLY(a_take_has_room, clock, reset, stat.take, stat.out_count <= QCNT_W'(QDEPTH - 2))

endmodule
